// ===== sv/priority_task_table_defines.svh =====
// Assertion macros shared by the priority task table checker.
`ifndef PRIORITY_TASK_TABLE_DEFINES_SVH
`define PRIORITY_TASK_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("priority task table check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("priority task table check failed");

`endif

// ===== sv/ptt_pkg.sv =====
// Types and constants of the priority task table.
package ptt_pkg;

   localparam int ENTRIES_DEF   = 64;
   localparam int ID_BITS_DEF   = 16;
   localparam int PRIO_BITS_DEF = 32;
   localparam int FIELD_ID_W    = 16;
   localparam int FIELD_PRIO_W  = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_EDIT   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_TOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WR_NONE = 2'd0,
      WR_FILL = 2'd1,
      WR_PRIO = 2'd2,
      WR_FREE = 2'd3
   } wr_kind_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [FIELD_ID_W-1:0]   task_id;
      logic [FIELD_ID_W-1:0]   user_id;
      logic [FIELD_PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [FIELD_ID_W-1:0] top_user;
   } rsp_type;

   // Control part of the search word that travels down the cell chain.
   typedef struct packed {
      logic       vld;
      opcode_type op;
      logic       hit;
      logic       free_ok;
      logic       top_ok;
   } scan_flags_type;

endpackage

// ===== sv/ptt_cell.sv =====
// One table slot: holds a task and updates the passing search word.
module ptt_cell #(
   parameter int ENTRIES   = ptt_pkg::ENTRIES_DEF,
   parameter int ID_BITS   = ptt_pkg::ID_BITS_DEF,
   parameter int PRIO_BITS = ptt_pkg::PRIO_BITS_DEF,
   parameter int SLOT      = 0,
   localparam int SLOT_BITS = $clog2(ENTRIES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptt_pkg::scan_flags_type in_flags,
   input  logic [ID_BITS-1:0]     in_id,
   input  logic [ID_BITS-1:0]     in_user,
   input  logic [PRIO_BITS-1:0]   in_prio,
   input  logic [SLOT_BITS-1:0]   in_hit_slot,
   input  logic [SLOT_BITS-1:0]   in_free_slot,
   input  logic [PRIO_BITS-1:0]   in_top_prio,
   input  logic [ID_BITS-1:0]     in_top_id,
   input  logic [ID_BITS-1:0]     in_top_user,
   input  logic [SLOT_BITS-1:0]   in_top_slot,
   output ptt_pkg::scan_flags_type out_flags,
   output logic [ID_BITS-1:0]     out_id,
   output logic [ID_BITS-1:0]     out_user,
   output logic [PRIO_BITS-1:0]   out_prio,
   output logic [SLOT_BITS-1:0]   out_hit_slot,
   output logic [SLOT_BITS-1:0]   out_free_slot,
   output logic [PRIO_BITS-1:0]   out_top_prio,
   output logic [ID_BITS-1:0]     out_top_id,
   output logic [ID_BITS-1:0]     out_top_user,
   output logic [SLOT_BITS-1:0]   out_top_slot,
   input  ptt_pkg::wr_kind_type   wr_kind,
   input  logic [SLOT_BITS-1:0]   wr_slot,
   input  logic [ID_BITS-1:0]     wr_id,
   input  logic [ID_BITS-1:0]     wr_user,
   input  logic [PRIO_BITS-1:0]   wr_prio
);

   localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(SLOT);

   logic                   live_ff, live_in;
   logic [ID_BITS-1:0]     task_ff, task_in;
   logic [ID_BITS-1:0]     user_ff, user_in;
   logic [PRIO_BITS-1:0]   prio_ff, prio_in;

   ptt_pkg::scan_flags_type flags_ff, flags_in;
   logic [ID_BITS-1:0]     id_ff, user_word_ff;
   logic [PRIO_BITS-1:0]   prio_word_ff;
   logic [SLOT_BITS-1:0]   hit_slot_ff, hit_slot_in;
   logic [SLOT_BITS-1:0]   free_slot_ff, free_slot_in;
   logic [PRIO_BITS-1:0]   top_prio_ff, top_prio_in;
   logic [ID_BITS-1:0]     top_id_ff, top_id_in;
   logic [ID_BITS-1:0]     top_user_ff, top_user_in;
   logic [SLOT_BITS-1:0]   top_slot_ff, top_slot_in;

   logic better;

   always_comb begin
      live_in = live_ff;
      task_in = task_ff;
      user_in = user_ff;
      prio_in = prio_ff;
      if (wr_slot == MY_SLOT) begin
         case (wr_kind)
            ptt_pkg::WR_FILL: begin
               live_in = 1'b1;
               task_in = wr_id;
               user_in = wr_user;
               prio_in = wr_prio;
            end
            ptt_pkg::WR_PRIO: prio_in = wr_prio;
            ptt_pkg::WR_FREE: live_in = 1'b0;
            default: ;
         endcase
      end
   end

   // Ties on priority go to the larger id; ids of live tasks are unique.
   assign better = live_ff && (!in_flags.top_ok || (prio_ff > in_top_prio) ||
                   ((prio_ff == in_top_prio) && (task_ff > in_top_id)));

   always_comb begin
      flags_in     = in_flags;
      hit_slot_in  = in_hit_slot;
      free_slot_in = in_free_slot;
      top_prio_in  = in_top_prio;
      top_id_in    = in_top_id;
      top_user_in  = in_top_user;
      top_slot_in  = in_top_slot;
      if (live_ff && (task_ff == in_id) && !in_flags.hit) begin
         flags_in.hit = 1'b1;
         hit_slot_in  = MY_SLOT;
      end
      if (!live_ff && !in_flags.free_ok) begin
         flags_in.free_ok = 1'b1;
         free_slot_in     = MY_SLOT;
      end
      if (better) begin
         flags_in.top_ok = 1'b1;
         top_prio_in     = prio_ff;
         top_id_in       = task_ff;
         top_user_in     = user_ff;
         top_slot_in     = MY_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= 1'b0;
         flags_ff <= '0;
      end else begin
         live_ff  <= live_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff      <= task_in;
      user_ff      <= user_in;
      prio_ff      <= prio_in;
      id_ff        <= in_id;
      user_word_ff <= in_user;
      prio_word_ff <= in_prio;
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      top_prio_ff  <= top_prio_in;
      top_id_ff    <= top_id_in;
      top_user_ff  <= top_user_in;
      top_slot_ff  <= top_slot_in;
   end

   assign out_flags     = flags_ff;
   assign out_id        = id_ff;
   assign out_user      = user_word_ff;
   assign out_prio      = prio_word_ff;
   assign out_hit_slot  = hit_slot_ff;
   assign out_free_slot = free_slot_ff;
   assign out_top_prio  = top_prio_ff;
   assign out_top_id    = top_id_ff;
   assign out_top_user  = top_user_ff;
   assign out_top_slot  = top_slot_ff;

endmodule

// ===== sv/priority_task_table.sv =====
// Top level of the priority task table: cell chain and command sequencer.
//
//   channel | direction | payload            | handshake
//   req     | in        | ptt_pkg::req_type  | req_valid / req_ready
//   rsp     | out       | ptt_pkg::rsp_type  | rsp_valid / rsp_ready
//
// A command's search word is registered in every cell as it walks the chain,
// is captured at the tail and then commits the write.
// The commit waits while an earlier word still sits unclaimed on rsp.
// Reset clears every live bit at once; no clearing pass is needed.
// A new command is taken as soon as the previous one has committed.
module priority_task_table #(
   parameter int ENTRIES   = ptt_pkg::ENTRIES_DEF,
   parameter int ID_BITS   = ptt_pkg::ID_BITS_DEF,
   parameter int PRIO_BITS = ptt_pkg::PRIO_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ptt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ptt_pkg::rsp_type rsp_data
);

   localparam int SLOT_BITS = $clog2(ENTRIES);

   ptt_pkg::scan_flags_type st_flags     [ENTRIES+1];
   logic [ID_BITS-1:0]      st_id        [ENTRIES+1];
   logic [ID_BITS-1:0]      st_user      [ENTRIES+1];
   logic [PRIO_BITS-1:0]    st_prio      [ENTRIES+1];
   logic [SLOT_BITS-1:0]    st_hit_slot  [ENTRIES+1];
   logic [SLOT_BITS-1:0]    st_free_slot [ENTRIES+1];
   logic [PRIO_BITS-1:0]    st_top_prio  [ENTRIES+1];
   logic [ID_BITS-1:0]      st_top_id    [ENTRIES+1];
   logic [ID_BITS-1:0]      st_top_user  [ENTRIES+1];
   logic [SLOT_BITS-1:0]    st_top_slot  [ENTRIES+1];

   ptt_pkg::state_type      state_ff, state_in;
   ptt_pkg::scan_flags_type res_flags_ff;
   logic [ID_BITS-1:0]      res_id_ff, res_user_ff, res_top_user_ff;
   logic [PRIO_BITS-1:0]    res_prio_ff;
   logic [SLOT_BITS-1:0]    res_hit_slot_ff, res_free_slot_ff, res_top_slot_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   ptt_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    out_free;
   logic                    finish_go;
   ptt_pkg::wr_kind_type    dec_kind, wr_kind;
   logic [SLOT_BITS-1:0]    wr_slot;
   ptt_pkg::status_type     dec_status;
   logic [ID_BITS-1:0]      dec_user;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Head of the chain: a fresh search word.
   always_comb begin
      st_flags[0]         = '0;
      st_flags[0].vld     = accept;
      st_flags[0].op      = req_data.opcode;
      st_id[0]            = ID_BITS'(req_data.task_id);
      st_user[0]          = ID_BITS'(req_data.user_id);
      st_prio[0]          = PRIO_BITS'(req_data.priority_req);
      st_hit_slot[0]      = '0;
      st_free_slot[0]     = '0;
      st_top_prio[0]      = '0;
      st_top_id[0]        = '0;
      st_top_user[0]      = '0;
      st_top_slot[0]      = '0;
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      ptt_cell #(
         .ENTRIES   (ENTRIES),
         .ID_BITS   (ID_BITS),
         .PRIO_BITS (PRIO_BITS),
         .SLOT      (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .in_flags      (st_flags[g]),
         .in_id         (st_id[g]),
         .in_user       (st_user[g]),
         .in_prio       (st_prio[g]),
         .in_hit_slot   (st_hit_slot[g]),
         .in_free_slot  (st_free_slot[g]),
         .in_top_prio   (st_top_prio[g]),
         .in_top_id     (st_top_id[g]),
         .in_top_user   (st_top_user[g]),
         .in_top_slot   (st_top_slot[g]),
         .out_flags     (st_flags[g+1]),
         .out_id        (st_id[g+1]),
         .out_user      (st_user[g+1]),
         .out_prio      (st_prio[g+1]),
         .out_hit_slot  (st_hit_slot[g+1]),
         .out_free_slot (st_free_slot[g+1]),
         .out_top_prio  (st_top_prio[g+1]),
         .out_top_id    (st_top_id[g+1]),
         .out_top_user  (st_top_user[g+1]),
         .out_top_slot  (st_top_slot[g+1]),
         .wr_kind       (wr_kind),
         .wr_slot       (wr_slot),
         .wr_id         (res_id_ff),
         .wr_user       (res_user_ff),
         .wr_prio       (res_prio_ff)
      );
   end

   // The tail word is present for one cycle only, so it is held here.
   always_ff @(posedge clock) begin
      if (st_flags[ENTRIES].vld) begin
         res_flags_ff     <= st_flags[ENTRIES];
         res_id_ff        <= st_id[ENTRIES];
         res_user_ff      <= st_user[ENTRIES];
         res_prio_ff      <= st_prio[ENTRIES];
         res_hit_slot_ff  <= st_hit_slot[ENTRIES];
         res_free_slot_ff <= st_free_slot[ENTRIES];
         res_top_user_ff  <= st_top_user[ENTRIES];
         res_top_slot_ff  <= st_top_slot[ENTRIES];
      end
   end

   // Decide the table update and the status from the finished search.
   always_comb begin
      dec_kind   = ptt_pkg::WR_NONE;
      wr_slot    = res_hit_slot_ff;
      dec_status = ptt_pkg::ST_OK;
      dec_user   = '0;
      case (res_flags_ff.op)
         ptt_pkg::OP_ADD: begin
            if (res_flags_ff.hit) begin
               dec_kind = ptt_pkg::WR_FILL;
            end else if (res_flags_ff.free_ok) begin
               dec_kind = ptt_pkg::WR_FILL;
               wr_slot  = res_free_slot_ff;
            end else begin
               dec_status = ptt_pkg::ST_FULL;
            end
         end
         ptt_pkg::OP_EDIT: begin
            if (res_flags_ff.hit) dec_kind = ptt_pkg::WR_PRIO;
            else dec_status = ptt_pkg::ST_MISSING;
         end
         ptt_pkg::OP_REMOVE: begin
            if (res_flags_ff.hit) dec_kind = ptt_pkg::WR_FREE;
            else dec_status = ptt_pkg::ST_MISSING;
         end
         ptt_pkg::OP_TOP: begin
            if (res_flags_ff.top_ok) begin
               dec_kind = ptt_pkg::WR_FREE;
               wr_slot  = res_top_slot_ff;
               dec_user = res_top_user_ff;
            end else begin
               dec_status = ptt_pkg::ST_EMPTY;
            end
         end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptt_pkg::S_IDLE:   if (accept) state_in = ptt_pkg::S_SCAN;
         ptt_pkg::S_SCAN:   if (st_flags[ENTRIES].vld) state_in = ptt_pkg::S_FINISH;
         ptt_pkg::S_FINISH: if (out_free) state_in = ptt_pkg::S_IDLE;
         default:           state_in = ptt_pkg::S_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         ptt_pkg::S_IDLE:   req_ready = 1'b1;
         ptt_pkg::S_FINISH: finish_go = out_free;
         default: ;
      endcase
   end

   assign wr_kind = finish_go ? dec_kind : ptt_pkg::WR_NONE;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (finish_go) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = dec_status;
         rsp_data_in.top_user = ptt_pkg::FIELD_ID_W'(dec_user);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/ptt_checker.sv =====
// Port-level checks for the priority task table, bound to the top level.
`include "priority_task_table_defines.svh"

module ptt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ptt_pkg::rsp_type rsp_data
);

   logic rsp_stall;
   logic rsp_err;
   logic req_take;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_err   = rsp_valid && (rsp_data.status != ptt_pkg::ST_OK);
   assign req_take  = req_valid && req_ready;

   // A refused result word must wait unchanged.
   `PTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // Only a successful take-top reports a user id.
   `PTT_ASSERT_SAME(a_user_zero, clock, reset, rsp_err, rsp_data.top_user == '0)

   // A command in flight blocks the next one for at least the following cycle.
   `PTT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, !req_ready)

   // A new result word only appears straight after input was refused.
   `PTT_ASSERT_SAME(a_fresh_rsp_idle, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind priority_task_table ptt_checker u_ptt_checker (.*);
